@@ rtl/dph_pkg.sv @@
`timescale 1ns / 1ps
package dph_pkg;

   // Widths of the internal fixed-point values
   localparam int MSQ_W      = 35;  // mass square of a configured mass, unsigned Q.26
   localparam int SQ_W       = 39;  // pair mass square, signed Q.26, unsaturated
   localparam int PROD_W     = 80;  // signed product of two SQ_W values
   localparam int L_W        = 76;  // momentum square term, nonnegative when valid
   localparam int N_W        = 78;  // cosine numerator, signed
   localparam int ROOT_W     = 38;  // floor square root of an L_W value
   localparam int REM_W      = 42;  // square root partial remainder
   localparam int R_W        = 78;  // division partial remainder
   localparam int Q_W        = 31;  // cosine magnitude, Q1.30
   localparam int SQRT_STEPS = L_W / 2;
   localparam int DIV_STEPS  = 30;
   localparam int ANGLE_LAT  = 7 + SQRT_STEPS + DIV_STEPS;
   localparam int NUM_ANGLES = 6;

   localparam logic [1:0] STATUS_OK     = 2'd0;
   localparam logic [1:0] STATUS_BAD_ID = 2'd1;
   localparam logic [1:0] STATUS_BEYOND = 2'd2;

   localparam logic [1:0] PAIR_23      = 2'd0;
   localparam logic [1:0] PAIR_13      = 2'd1;
   localparam logic [1:0] PAIR_12      = 2'd2;
   localparam logic [1:0] PAIR_INVALID = 2'd3;

   typedef enum logic [1:0] {
      REG_MOTHER_MASS    = 2'd0,
      REG_DAUGHTER1_MASS = 2'd1,
      REG_DAUGHTER2_MASS = 2'd2,
      REG_DAUGHTER3_MASS = 2'd3
   } csr_reg_type;

   typedef struct packed {
      logic [1:0]         first_pair_id;
      logic [1:0]         second_pair_id;
      logic signed [31:0] first_mass_sq;
      logic signed [31:0] second_mass_sq;
   } req_type;

   typedef struct packed {
      logic signed [31:0] mass_sq_23;
      logic signed [31:0] mass_sq_13;
      logic signed [31:0] mass_sq_12;
      logic signed [31:0] cos_12_vs_13;
      logic signed [31:0] cos_12_vs_23;
      logic signed [31:0] cos_13_vs_12;
      logic signed [31:0] cos_13_vs_23;
      logic signed [31:0] cos_23_vs_13;
      logic signed [31:0] cos_23_vs_12;
      logic [1:0]         status;
   } rsp_type;

   typedef struct packed {
      logic [MSQ_W-1:0]       msq;
      logic [MSQ_W-1:0]       a2;
      logic [MSQ_W-1:0]       b2;
      logic [MSQ_W-1:0]       c2;
      logic signed [SQ_W-1:0] s;
      logic signed [SQ_W-1:0] t;
   } ang_in_type;

   typedef struct packed {
      logic               beyond;
      logic signed [31:0] cosv;
   } ang_out_type;

   // Partial products of a sign-magnitude 38 x 38 multiply, split at bit 32
   typedef struct packed {
      logic [63:0] ll;
      logic [37:0] lh;
      logic [37:0] hl;
      logic [11:0] hh;
      logic        neg;
   } pp_type;

   typedef struct packed {
      logic [L_W-1:0]    x;
      logic [REM_W-1:0]  rem;
      logic [ROOT_W-1:0] root;
   } sqrt_type;

   typedef struct packed {
      logic [R_W-1:0] r;
      logic [Q_W-1:0] q;
   } div_type;

   // Mass (Q4.28) squared, rounded half up to Q.26
   function automatic logic [MSQ_W-1:0] mass_square(input logic [31:0] m);
      logic [63:0] p;
      p = 64'(m) * 64'(m);
      return MSQ_W'(p[63:30]) + MSQ_W'(p[29]);
   endfunction

   function automatic logic signed [SQ_W-1:0] msq_ext(input logic [MSQ_W-1:0] v);
      return signed'({{(SQ_W-MSQ_W){1'b0}}, v});
   endfunction

   function automatic pp_type pp_make(input logic signed [SQ_W-1:0] x,
                                      input logic signed [SQ_W-1:0] y);
      logic [SQ_W-1:0] xm;
      logic [SQ_W-1:0] ym;
      pp_type pp;
      xm = x[SQ_W-1] ? SQ_W'(-x) : SQ_W'(x);
      ym = y[SQ_W-1] ? SQ_W'(-y) : SQ_W'(y);
      pp.ll  = 64'(xm[31:0]) * 64'(ym[31:0]);
      pp.lh  = 38'(xm[31:0]) * 38'(ym[37:32]);
      pp.hl  = 38'(xm[37:32]) * 38'(ym[31:0]);
      pp.hh  = 12'(xm[37:32]) * 12'(ym[37:32]);
      pp.neg = x[SQ_W-1] ^ y[SQ_W-1];
      return pp;
   endfunction

   function automatic logic signed [PROD_W-1:0] pp_sum(input pp_type pp);
      logic [PROD_W-1:0] mag;
      mag = (PROD_W'(pp.hh) << 64) + (PROD_W'(pp.lh) << 32)
          + (PROD_W'(pp.hl) << 32) + PROD_W'(pp.ll);
      return pp.neg ? signed'(-mag) : signed'(mag);
   endfunction

   // One digit of the restoring square root: two operand bits per step
   function automatic sqrt_type sqrt_step(input sqrt_type v);
      logic [REM_W-1:0] rs;
      logic [REM_W-1:0] trial;
      logic             ge;
      sqrt_type         o;
      rs      = {v.rem[REM_W-3:0], v.x[L_W-1:L_W-2]};
      trial   = {{(REM_W-ROOT_W-2){1'b0}}, v.root, 2'b01};
      ge      = rs >= trial;
      o.rem   = ge ? rs - trial : rs;
      o.root  = {v.root[ROOT_W-2:0], ge};
      o.x     = {v.x[L_W-3:0], 2'b00};
      return o;
   endfunction

   // One quotient bit of the restoring division
   function automatic div_type div_step(input div_type v, input logic [L_W-1:0] d);
      logic [R_W-1:0] rs;
      logic           ge;
      div_type        o;
      rs  = {v.r[R_W-2:0], 1'b0};
      ge  = rs >= R_W'(d);
      o.r = ge ? rs - R_W'(d) : rs;
      o.q = {v.q[Q_W-2:0], ge};
      return o;
   endfunction

endpackage

@@ rtl/dph_angle.sv @@
`timescale 1ns / 1ps
module dph_angle import dph_pkg::*; (
   input  logic        clock,
   input  logic        en,
   input  ang_in_type  ang_in,
   output ang_out_type ang_out
);

   // stage 1: A, B, t - a^2 - c^2
   logic signed [SQ_W-1:0] a_ff, b_ff, u_ff, s1_ff;
   logic [MSQ_W-1:0]       a2_1_ff, c2_1_ff;
   logic                   bad1_ff;
   logic signed [SQ_W-1:0] a_in, b_in, u_in;
   logic                   bad1_in;

   always_comb begin
      a_in    = ang_in.s + msq_ext(ang_in.a2) - msq_ext(ang_in.b2);
      b_in    = msq_ext(ang_in.msq) - msq_ext(ang_in.c2) - ang_in.s;
      u_in    = ang_in.t - msq_ext(ang_in.a2) - msq_ext(ang_in.c2);
      bad1_in = ang_in.s[SQ_W-1] || (ang_in.s == '0);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_ff    <= a_in;
         b_ff    <= b_in;
         u_ff    <= u_in;
         s1_ff   <= ang_in.s;
         a2_1_ff <= ang_in.a2;
         c2_1_ff <= ang_in.c2;
         bad1_ff <= bad1_in;
      end
   end

   // stage 2: partial products
   pp_type pp_aa_ff, pp_sa_ff, pp_bb_ff, pp_sc_ff, pp_ab_ff, pp_su_ff;
   logic   bad2_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         pp_aa_ff <= pp_make(a_ff, a_ff);
         pp_sa_ff <= pp_make(s1_ff, msq_ext(a2_1_ff));
         pp_bb_ff <= pp_make(b_ff, b_ff);
         pp_sc_ff <= pp_make(s1_ff, msq_ext(c2_1_ff));
         pp_ab_ff <= pp_make(a_ff, b_ff);
         pp_su_ff <= pp_make(s1_ff, u_ff);
         bad2_ff  <= bad1_ff;
      end
   end

   // stage 3: products
   logic signed [PROD_W-1:0] p_aa_ff, p_sa_ff, p_bb_ff, p_sc_ff, p_ab_ff, p_su_ff;
   logic                     bad3_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         p_aa_ff <= pp_sum(pp_aa_ff);
         p_sa_ff <= pp_sum(pp_sa_ff);
         p_bb_ff <= pp_sum(pp_bb_ff);
         p_sc_ff <= pp_sum(pp_sc_ff);
         p_ab_ff <= pp_sum(pp_ab_ff);
         p_su_ff <= pp_sum(pp_su_ff);
         bad3_ff <= bad2_ff;
      end
   end

   // stage 4: L1, L2, N
   logic signed [PROD_W-1:0] l1_full, l2_full, n_full;

   always_comb begin
      l1_full = p_aa_ff - (p_sa_ff <<< 2);
      l2_full = p_bb_ff - (p_sc_ff <<< 2);
      n_full  = p_ab_ff - (p_su_ff <<< 1);
   end

   sqrt_type              sq1_ff [SQRT_STEPS+1];
   sqrt_type              sq2_ff [SQRT_STEPS+1];
   logic signed [N_W-1:0] nq_ff  [SQRT_STEPS+1];
   logic                  badq_ff[SQRT_STEPS+1];

   always_ff @(posedge clock) begin
      if (en) begin
         sq1_ff[0]  <= '{x: l1_full[L_W-1:0], rem: '0, root: '0};
         sq2_ff[0]  <= '{x: l2_full[L_W-1:0], rem: '0, root: '0};
         nq_ff[0]   <= n_full[N_W-1:0];
         badq_ff[0] <= bad3_ff || l1_full[PROD_W-1] || l2_full[PROD_W-1];
      end
   end

   // square root pipeline, one root bit per stage
   for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
      always_ff @(posedge clock) begin
         if (en) begin
            sq1_ff[k+1]  <= sqrt_step(sq1_ff[k]);
            sq2_ff[k+1]  <= sqrt_step(sq2_ff[k]);
            nq_ff[k+1]   <= nq_ff[k];
            badq_ff[k+1] <= badq_ff[k];
         end
      end
   end

   // stage: divisor partial products, then divisor
   pp_type                pp_d_ff;
   logic signed [N_W-1:0] n5_ff, n6_ff;
   logic                  bad5_ff, bad6_ff;
   logic [L_W-1:0]        d6_ff;
   logic signed [PROD_W-1:0] d_full;

   assign d_full = pp_sum(pp_d_ff);

   always_ff @(posedge clock) begin
      if (en) begin
         pp_d_ff <= pp_make(signed'({1'b0, sq1_ff[SQRT_STEPS].root}),
                            signed'({1'b0, sq2_ff[SQRT_STEPS].root}));
         n5_ff   <= nq_ff[SQRT_STEPS];
         bad5_ff <= badq_ff[SQRT_STEPS];
         d6_ff   <= d_full[L_W-1:0];
         n6_ff   <= n5_ff;
         bad6_ff <= bad5_ff;
      end
   end

   // stage: magnitude check and integer quotient bit
   logic [N_W-1:0] n_mag;
   logic           n_gt, n_eq;

   always_comb begin
      n_mag = n6_ff[N_W-1] ? N_W'(-n6_ff) : N_W'(n6_ff);
      n_gt  = R_W'(n_mag) > R_W'(d6_ff);
      n_eq  = R_W'(n_mag) == R_W'(d6_ff);
   end

   div_type        dv_ff  [DIV_STEPS+1];
   logic [L_W-1:0] dd_ff  [DIV_STEPS+1];
   logic           neg_ff [DIV_STEPS+1];
   logic           badd_ff[DIV_STEPS+1];

   always_ff @(posedge clock) begin
      if (en) begin
         dv_ff[0].r  <= n_eq ? '0 : R_W'(n_mag);
         dv_ff[0].q  <= Q_W'(n_eq);
         dd_ff[0]    <= d6_ff;
         neg_ff[0]   <= n6_ff[N_W-1];
         badd_ff[0]  <= bad6_ff || (d6_ff == '0) || n_gt;
      end
   end

   // fraction bits, one per stage
   for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
      always_ff @(posedge clock) begin
         if (en) begin
            dv_ff[k+1]   <= div_step(dv_ff[k], dd_ff[k]);
            dd_ff[k+1]   <= dd_ff[k];
            neg_ff[k+1]  <= neg_ff[k];
            badd_ff[k+1] <= badd_ff[k];
         end
      end
   end

   always_comb begin
      ang_out.beyond = badd_ff[DIV_STEPS];
      if (badd_ff[DIV_STEPS]) begin
         ang_out.cosv = '0;
      end else if (neg_ff[DIV_STEPS]) begin
         ang_out.cosv = -signed'(32'(dv_ff[DIV_STEPS].q));
      end else begin
         ang_out.cosv = signed'(32'(dv_ff[DIV_STEPS].q));
      end
   end

endmodule

@@ rtl/dalitz_point_helicity_angles.sv @@
`timescale 1ns / 1ps
// Dalitz point helicity angles.
// Request channel (req_valid / req_stall / req_data): two pair mass squares,
// each tagged with its pair id. Response channel (rsp_valid / rsp_stall /
// rsp_data): the three mass squares, six helicity cosines and a status.
// A transfer happens on an edge with valid high and stall low.
// Config port: csr_write with csr_index / csr_wdata writes one of the four
// masses; the mass square is formed on the write, so a request may follow on
// the next cycle. Write only while no request is in flight.
// Throughput: one request per cycle while req_stall is low. A request passes
// through the input register, then 75 stages of the angle pipeline (38 square
// root steps and 30 division steps dominate), then the output register.
// A one-entry skid buffer sits behind the output register: req_stall rises
// only once the output is held and the skid entry is full; the whole pipeline
// then freezes, losing nothing.
// Reset clears all valid bits and the masses to zero.
module dalitz_point_helicity_angles import dph_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   typedef struct packed {
      logic               idbad;
      logic signed [31:0] m23;
      logic signed [31:0] m13;
      logic signed [31:0] m12;
   } meta_type;

   logic [MSQ_W-1:0] msq_ff, d1sq_ff, d2sq_ff, d3sq_ff;
   logic [MSQ_W-1:0] wsq;

   assign wsq = mass_square(csr_wdata);

   always_ff @(posedge clock) begin
      if (reset) begin
         msq_ff  <= '0;
         d1sq_ff <= '0;
         d2sq_ff <= '0;
         d3sq_ff <= '0;
      end else if (csr_write) begin
         unique case (csr_reg_type'(csr_index))
            REG_MOTHER_MASS:    msq_ff  <= wsq;
            REG_DAUGHTER1_MASS: d1sq_ff <= wsq;
            REG_DAUGHTER2_MASS: d2sq_ff <= wsq;
            REG_DAUGHTER3_MASS: d3sq_ff <= wsq;
         endcase
      end
   end

   logic en;
   logic skid_valid_ff, skid_valid_in;
   logic rsp_valid_ff, rsp_valid_in;
   rsp_type skid_data_ff, skid_data_in, rsp_data_ff, rsp_data_in;

   assign en        = !skid_valid_ff;
   assign req_stall = skid_valid_ff;

   // input stage: place the two values and derive the third
   logic signed [SQ_W-1:0] sq_ff [3];
   logic signed [SQ_W-1:0] sq_in [3];
   logic                   t1_valid_ff, idbad_ff, idbad_in;
   logic signed [SQ_W-1:0] x_ext, y_ext, third;

   always_comb begin
      x_ext = SQ_W'(req_data.first_mass_sq);
      y_ext = SQ_W'(req_data.second_mass_sq);
      third = msq_ext(msq_ff) + msq_ext(d1sq_ff) + msq_ext(d2sq_ff) + msq_ext(d3sq_ff)
            - x_ext - y_ext;
      idbad_in = (req_data.first_pair_id == PAIR_INVALID)
              || (req_data.second_pair_id == PAIR_INVALID)
              || (req_data.first_pair_id == req_data.second_pair_id);
      for (int j = 0; j < 3; j++) begin
         priority if (req_data.first_pair_id == 2'(j)) begin
            sq_in[j] = x_ext;
         end else if (req_data.second_pair_id == 2'(j)) begin
            sq_in[j] = y_ext;
         end else begin
            sq_in[j] = third;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         t1_valid_ff <= 1'b0;
      end else if (en) begin
         t1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sq_ff    <= sq_in;
         idbad_ff <= idbad_in;
      end
   end

   function automatic logic signed [31:0] sat32(input logic signed [SQ_W-1:0] v);
      if (v > SQ_W'(32'sh7fff_ffff)) return 32'sh7fff_ffff;
      if (v < -SQ_W'(33'sh0_8000_0000)) return 32'sh8000_0000;
      return v[31:0];
   endfunction

   // angle units
   ang_in_type  ang_in [NUM_ANGLES];
   ang_out_type ang_out[NUM_ANGLES];

   always_comb begin
      ang_in[0] = '{msq_ff, d1sq_ff, d2sq_ff, d3sq_ff, sq_ff[PAIR_12], sq_ff[PAIR_13]};
      ang_in[1] = '{msq_ff, d2sq_ff, d1sq_ff, d3sq_ff, sq_ff[PAIR_12], sq_ff[PAIR_23]};
      ang_in[2] = '{msq_ff, d1sq_ff, d3sq_ff, d2sq_ff, sq_ff[PAIR_13], sq_ff[PAIR_12]};
      ang_in[3] = '{msq_ff, d3sq_ff, d1sq_ff, d2sq_ff, sq_ff[PAIR_13], sq_ff[PAIR_23]};
      ang_in[4] = '{msq_ff, d3sq_ff, d2sq_ff, d1sq_ff, sq_ff[PAIR_23], sq_ff[PAIR_13]};
      ang_in[5] = '{msq_ff, d2sq_ff, d3sq_ff, d1sq_ff, sq_ff[PAIR_23], sq_ff[PAIR_12]};
   end

   for (genvar g = 0; g < NUM_ANGLES; g++) begin : g_angle
      dph_angle u_angle (
         .clock   (clock),
         .en      (en),
         .ang_in  (ang_in[g]),
         .ang_out (ang_out[g])
      );
   end

   // side pipeline matching the angle units
   logic     valid_ff[ANGLE_LAT];
   meta_type meta_ff [ANGLE_LAT];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < ANGLE_LAT; k++) valid_ff[k] <= 1'b0;
      end else if (en) begin
         valid_ff[0] <= t1_valid_ff;
         for (int k = 1; k < ANGLE_LAT; k++) valid_ff[k] <= valid_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         meta_ff[0] <= '{idbad_ff, sat32(sq_ff[PAIR_23]), sat32(sq_ff[PAIR_13]),
                         sat32(sq_ff[PAIR_12])};
         for (int k = 1; k < ANGLE_LAT; k++) meta_ff[k] <= meta_ff[k-1];
      end
   end

   // result assembly
   logic     last_valid;
   meta_type last_meta;
   rsp_type  last_data;
   logic     any_beyond;

   always_comb begin
      last_valid = valid_ff[ANGLE_LAT-1];
      last_meta  = meta_ff[ANGLE_LAT-1];
      any_beyond = 1'b0;
      for (int g = 0; g < NUM_ANGLES; g++) any_beyond |= ang_out[g].beyond;
      last_data = '0;
      if (last_meta.idbad) begin
         last_data.status = STATUS_BAD_ID;
      end else begin
         last_data.mass_sq_23 = last_meta.m23;
         last_data.mass_sq_13 = last_meta.m13;
         last_data.mass_sq_12 = last_meta.m12;
         if (any_beyond) begin
            last_data.status = STATUS_BEYOND;
         end else begin
            last_data.status       = STATUS_OK;
            last_data.cos_12_vs_13 = ang_out[0].cosv;
            last_data.cos_12_vs_23 = ang_out[1].cosv;
            last_data.cos_13_vs_12 = ang_out[2].cosv;
            last_data.cos_13_vs_23 = ang_out[3].cosv;
            last_data.cos_23_vs_13 = ang_out[4].cosv;
            last_data.cos_23_vs_12 = ang_out[5].cosv;
         end
      end
   end

   // output register with skid entry
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (rsp_valid_ff && rsp_stall) begin
         if (en && last_valid) begin
            skid_valid_in = 1'b1;
            skid_data_in  = last_data;
         end
      end else if (skid_valid_ff) begin
         rsp_valid_in  = 1'b1;
         rsp_data_in   = skid_data_ff;
         skid_valid_in = 1'b0;
      end else begin
         rsp_valid_in = last_valid;
         rsp_data_in  = last_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff  <= rsp_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef ASSERT_OFF
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid entry held without a pending output");

   a_skid_fill_on_stall: assert property (@(posedge clock) disable iff (reset)
      $rose(skid_valid_ff) |-> $past(rsp_stall) && $past(rsp_valid_ff))
      else $error("skid entry filled while output was free");

   a_bad_id_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_data_ff.status == STATUS_BAD_ID)
      |-> (rsp_data_ff.mass_sq_23 == 0) && (rsp_data_ff.mass_sq_13 == 0)
          && (rsp_data_ff.mass_sq_12 == 0))
      else $error("bad pair ids with nonzero mass squares");

   a_beyond_zero_cos: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_data_ff.status != STATUS_OK)
      |-> (rsp_data_ff.cos_12_vs_13 == 0) && (rsp_data_ff.cos_23_vs_12 == 0))
      else $error("error status with nonzero cosine");

   a_no_stall_when_skid_empty: assert property (@(posedge clock) disable iff (reset)
      !skid_valid_ff |-> !req_stall)
      else $error("request stalled with room in the pipeline");
`endif

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps
module tb_top;
   import dph_pkg::*;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   rsp_type     rsp_data;
   logic        csr_write = 1'b0;
   logic [1:0]  csr_index = '0;
   logic [31:0] csr_wdata = '0;

   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_CYCLES = 120;

   dalitz_point_helicity_angles dut (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   logic [31:0] mass_reg [4];
   rsp_type     pending_rsp [$];
   int          sender_idle_pct = 0;
   int          rcv_stall_pct = 0;
   int          hold_cycles = 0;
   int          errors = 0;
   int          n_sent = 0;
   int          n_checked = 0;
   int          cycles = 0;

   // ---------------- predictor ----------------
   function automatic longint mass_sq_of(logic [31:0] m);
      logic [63:0] p;
      p = 64'(m) * 64'(m);
      return longint'(p >> 30) + longint'(p[29]);
   endfunction

   function automatic logic [63:0] floor_root(logic [127:0] v);
      logic [63:0]  r;
      logic [63:0]  c;
      logic [127:0] sq;
      r = '0;
      for (int b = 45; b >= 0; b--) begin
         c = r | (64'd1 << b);
         sq = 128'(c) * 128'(c);
         if (sq <= v) r = c;
      end
      return r;
   endfunction

   // returns 1 when the point lies beyond phase space for this angle
   function automatic bit angle_cos(longint msq_i, longint a2_i, longint b2_i, longint c2_i,
                                    longint s_i, longint t_i, output longint cv);
      logic signed [127:0] ms, a2, b2, c2, s, t, A, B, l1, l2, n, d, mag;
      logic [127:0]        q;
      cv = 0;
      if (s_i <= 0) return 1'b1;
      ms = msq_i; a2 = a2_i; b2 = b2_i; c2 = c2_i; s = s_i; t = t_i;
      A = s + a2 - b2;
      B = ms - c2 - s;
      l1 = A * A - ((s * a2) <<< 2);
      l2 = B * B - ((s * c2) <<< 2);
      if (l1 < 0 || l2 < 0) return 1'b1;
      d = $signed(128'(floor_root(l1)) * 128'(floor_root(l2)));
      if (d == 0) return 1'b1;
      n = A * B - ((s * (t - a2 - c2)) <<< 1);
      mag = (n < 0) ? -n : n;
      if (mag > d) return 1'b1;
      q = (128'(mag) << 30) / 128'(d);
      cv = (n < 0) ? -longint'(q) : longint'(q);
      return 1'b0;
   endfunction

   function automatic logic [31:0] sat32(longint v);
      if (v > 64'sd2147483647) return 32'h7fffffff;
      if (v < -64'sd2147483648) return 32'h80000000;
      return v[31:0];
   endfunction

   function automatic rsp_type predict_point(req_type r);
      rsp_type o;
      longint  msq, s1, s2, s3;
      longint  sq [3];
      longint  cv [6];
      bit      beyond;
      int      a, b;
      o = '0;
      a = r.first_pair_id;
      b = r.second_pair_id;
      if (a == PAIR_INVALID || b == PAIR_INVALID || a == b) begin
         o.status = STATUS_BAD_ID;
         return o;
      end
      msq = mass_sq_of(mass_reg[REG_MOTHER_MASS]);
      s1 = mass_sq_of(mass_reg[REG_DAUGHTER1_MASS]);
      s2 = mass_sq_of(mass_reg[REG_DAUGHTER2_MASS]);
      s3 = mass_sq_of(mass_reg[REG_DAUGHTER3_MASS]);
      sq[a] = longint'(r.first_mass_sq);
      sq[b] = longint'(r.second_mass_sq);
      sq[3 - a - b] = msq + s1 + s2 + s3 - sq[a] - sq[b];
      beyond = 1'b0;
      beyond |= angle_cos(msq, s1, s2, s3, sq[PAIR_12], sq[PAIR_13], cv[0]);
      beyond |= angle_cos(msq, s2, s1, s3, sq[PAIR_12], sq[PAIR_23], cv[1]);
      beyond |= angle_cos(msq, s1, s3, s2, sq[PAIR_13], sq[PAIR_12], cv[2]);
      beyond |= angle_cos(msq, s3, s1, s2, sq[PAIR_13], sq[PAIR_23], cv[3]);
      beyond |= angle_cos(msq, s3, s2, s1, sq[PAIR_23], sq[PAIR_13], cv[4]);
      beyond |= angle_cos(msq, s2, s3, s1, sq[PAIR_23], sq[PAIR_12], cv[5]);
      o.mass_sq_23 = sat32(sq[PAIR_23]);
      o.mass_sq_13 = sat32(sq[PAIR_13]);
      o.mass_sq_12 = sat32(sq[PAIR_12]);
      if (beyond) begin
         o.status = STATUS_BEYOND;
         return o;
      end
      o.cos_12_vs_13 = cv[0][31:0];
      o.cos_12_vs_23 = cv[1][31:0];
      o.cos_13_vs_12 = cv[2][31:0];
      o.cos_13_vs_23 = cv[3][31:0];
      o.cos_23_vs_13 = cv[4][31:0];
      o.cos_23_vs_12 = cv[5][31:0];
      o.status = STATUS_OK;
      return o;
   endfunction

   // ---------------- drivers ----------------
   task automatic write_mass(csr_reg_type idx, logic [31:0] val);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      mass_reg[idx] = val;
      @(posedge clock);
      csr_write <= 1'b0;
      @(posedge clock);
   endtask

   task automatic queue_expected(rsp_type e);
      pending_rsp.insert(pending_rsp.size(), e);
   endtask

   task automatic send_point(req_type r, bit typed, rsp_type typed_rsp);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (req_stall);
      queue_expected(typed ? typed_rsp : predict_point(r));
      n_sent++;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      wait (pending_rsp.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // point inside the kinematic bounding box of the current masses
   function automatic req_type phys_point();
      req_type     r;
      longint      lo12, hi12, lo23, hi23, tot;
      longint      sq [3];
      logic [31:0] m0, m1, m2, m3;
      int          a, b;
      m0 = mass_reg[REG_MOTHER_MASS];
      m1 = mass_reg[REG_DAUGHTER1_MASS];
      m2 = mass_reg[REG_DAUGHTER2_MASS];
      m3 = mass_reg[REG_DAUGHTER3_MASS];
      lo12 = mass_sq_of(m1 + m2);
      hi12 = mass_sq_of(m0 - m3);
      lo23 = mass_sq_of(m2 + m3);
      hi23 = mass_sq_of(m0 - m1);
      tot = mass_sq_of(m0) + mass_sq_of(m1) + mass_sq_of(m2) + mass_sq_of(m3);
      sq[PAIR_12] = $urandom_range(32'(hi12), 32'(lo12));
      sq[PAIR_23] = $urandom_range(32'(hi23), 32'(lo23));
      sq[PAIR_13] = tot - sq[PAIR_12] - sq[PAIR_23];
      a = $urandom_range(2);
      b = (a + 1 + $urandom_range(1)) % 3;
      r.first_pair_id = a;
      r.second_pair_id = b;
      r.first_mass_sq = sq[a][31:0];
      r.second_mass_sq = sq[b][31:0];
      return r;
   endfunction

   function automatic req_type random_point(bit phys_ok);
      req_type r;
      int      pick;
      pick = $urandom_range(99);
      if (phys_ok && pick < 75) return phys_point();
      r.first_pair_id = $urandom_range(3);
      r.second_pair_id = $urandom_range(3);
      r.first_mass_sq = $urandom();
      r.second_mass_sq = $urandom();
      if (pick < 85 && phys_ok) r.second_pair_id = r.first_pair_id;
      return r;
   endfunction

   task automatic physical_config();
      logic [31:0] m0;
      m0 = $urandom_range(32'd1449551462, 32'd268435456);
      write_mass(REG_MOTHER_MASS, m0);
      write_mass(REG_DAUGHTER1_MASS, ($urandom_range(9) == 0) ? 32'd0 : $urandom_range(m0 / 4));
      write_mass(REG_DAUGHTER2_MASS, $urandom_range(m0 / 4));
      write_mass(REG_DAUGHTER3_MASS, $urandom_range(m0 / 4));
   endtask

   // ---------------- response checker ----------------
   always @(posedge clock) begin
      rsp_type e;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_rsp.size() == 0) begin
               $display("%0t: unexpected transfer, actual %h", $realtime, rsp_data);
               errors++;
            end else begin
               e = pending_rsp.pop_front();
               n_checked++;
               if (rsp_data !== e) begin
                  errors++;
                  $display("%0t: mismatch expected %h actual %h", $realtime, e, rsp_data);
                  if (rsp_data.status !== e.status)
                     $display("%0t:   status expected %0d actual %0d", $realtime,
                              e.status, rsp_data.status);
               end
            end
         end
      end
   end

   // receiver stall, with a long hold-off counted down here
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < rcv_stall_pct);
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d transfers outstanding", $realtime, pending_rsp.size());
         $display("** dalitz_point_helicity_angles: FAILED **");
         $finish;
      end
   end

   // ---------------- stimulus ----------------
   typedef struct {
      logic [1:0]  id1;
      logic [1:0]  id2;
      logic [31:0] v1;
      logic [31:0] v2;
      bit          typed;
   } row_type;

   localparam logic [31:0] GEV2 = 32'h0400_0000;

   row_type rows [] = '{
      '{PAIR_INVALID, PAIR_23, 32'h1234_5678, 32'h8765_4321, 1'b1},
      '{PAIR_13, PAIR_INVALID, 32'hffff_ffff, 32'h0, 1'b1},
      '{PAIR_12, PAIR_12, 2 * GEV2, 4 * GEV2, 1'b1},
      '{PAIR_INVALID, PAIR_INVALID, 32'h8000_0000, 32'h7fff_ffff, 1'b1},
      '{PAIR_12, PAIR_13, 2 * GEV2, 4 * GEV2, 1'b0},
      '{PAIR_13, PAIR_12, 4 * GEV2, 2 * GEV2, 1'b0},
      '{PAIR_23, PAIR_12, 32'h1200_0000, 2 * GEV2, 1'b0},
      '{PAIR_12, PAIR_23, 2 * GEV2, 32'h1200_0000, 1'b0},
      '{PAIR_23, PAIR_13, 32'h1200_0000, 4 * GEV2, 1'b0},
      '{PAIR_13, PAIR_23, 4 * GEV2, 32'h1200_0000, 1'b0},
      // edge of phase space: zero momentum gives a zero divisor
      '{PAIR_12, PAIR_13, GEV2, 4 * GEV2, 1'b0},
      '{PAIR_12, PAIR_13, 32'h7fff_ffff, 32'h7fff_ffff, 1'b0},
      // third square saturates high
      '{PAIR_12, PAIR_13, 32'h8000_0000, 32'h8000_0000, 1'b0},
      '{PAIR_23, PAIR_13, 32'h0, 32'h0, 1'b0},
      '{PAIR_12, PAIR_13, 32'hffff_ffff, 5 * GEV2, 1'b0},
      '{PAIR_12, PAIR_13, 3 * GEV2, 32'h1000_0000, 1'b0},
      '{PAIR_12, PAIR_23, 32'h1900_0000, 32'h0500_0000, 1'b0}
   };

   initial begin
      req_type r;
      rsp_type bad_rsp;
      int      kind;
      for (int i = 0; i < 4; i++) mass_reg[i] = '0;
      bad_rsp = '0;
      bad_rsp.status = STATUS_BAD_ID;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset values first, a few transfers
      for (int i = 0; i < 4; i++) begin
         r = random_point(1'b1);
         send_point(r, 1'b0, bad_rsp);
      end
      drain();

      write_mass(REG_MOTHER_MASS, 32'h3000_0000);
      write_mass(REG_DAUGHTER1_MASS, 32'h0800_0000);
      write_mass(REG_DAUGHTER2_MASS, 32'h0800_0000);
      write_mass(REG_DAUGHTER3_MASS, 32'h1000_0000);
      foreach (rows[i]) begin
         r.first_pair_id = rows[i].id1;
         r.second_pair_id = rows[i].id2;
         r.first_mass_sq = rows[i].v1;
         r.second_mass_sq = rows[i].v2;
         send_point(r, rows[i].typed, bad_rsp);
      end
      drain();

      for (int ph = 0; ph < 8; ph++) begin
         case (ph % 4)
            0: begin sender_idle_pct = 0;  rcv_stall_pct = 0;  end
            1: begin sender_idle_pct = 52; rcv_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  rcv_stall_pct = 52; end
            default: begin sender_idle_pct = 18; rcv_stall_pct = 18; end
         endcase
         kind = (ph == 1) ? 1 : (ph == 5) ? 0 : 2;
         if (kind == 1) begin
            for (int i = 0; i < 4; i++) write_mass(csr_reg_type'(i), 32'hffff_ffff);
         end else if (kind == 0) begin
            for (int i = 0; i < 4; i++) write_mass(csr_reg_type'(i), 32'h0);
         end else begin
            physical_config();
         end
         // long receiver hold-off while the sender keeps offering
         if (ph == 4) hold_cycles = 300;
         for (int i = 0; i < 180; i++) begin
            r = random_point(kind != 1);
            send_point(r, 1'b0, bad_rsp);
         end
         drain();
      end

      $display("covered %0d transfers over reset, extreme and physical mass settings,",
               n_sent);
      $display("with idle, stall and back-pressure phases; %0d responses checked", n_checked);
      if (errors == 0 && pending_rsp.size() == 0) begin
         $display("** dalitz_point_helicity_angles: PASSED **");
      end else begin
         $display("** dalitz_point_helicity_angles: FAILED **");
      end
      $finish;
   end
endmodule
